>>> sv/gpc_pkg.sv
// ----------------------------------------------------------------------------
// gpc_pkg: shared definitions for the gait phase classifier
// Widths, position codes, leg-status bit codes and the tracker state bundle.
// ----------------------------------------------------------------------------
package gpc_pkg;

  // number of calibration frames
  localparam int CAL_FRAMES = 100;

  localparam int AXIS_W   = 16;
  localparam int POS_W    = 2;
  localparam int STATUS_W = 8;
  localparam int MARGIN_W = AXIS_W - 1;
  localparam int CNT_W    = $clog2(CAL_FRAMES + 1);
  // calibration sums hold CAL_FRAMES signed readings
  localparam int SUM_W    = AXIS_W + $clog2(CAL_FRAMES);
  // CAL_FRAMES * (axis + margin), signed
  localparam int PROD_W   = AXIS_W + 1 + $clog2(CAL_FRAMES + 1);

  // sensor positions; low right ends a frame
  typedef enum logic [POS_W-1:0] {
    POS_HIGH_LEFT  = 2'd0,
    POS_HIGH_RIGHT = 2'd1,
    POS_LOW_LEFT   = 2'd2,
    POS_LOW_RIGHT  = 2'd3
  } pos_t;

  // leg-status bits
  localparam logic [STATUS_W-1:0] ST_RAISED_RIGHT   = 8'b1000_0000;
  localparam logic [STATUS_W-1:0] ST_LOWERED_RIGHT  = 8'b0100_0000;
  localparam logic [STATUS_W-1:0] ST_RAISED_LEFT    = 8'b0010_0000;
  localparam logic [STATUS_W-1:0] ST_LOWERED_LEFT   = 8'b0001_0000;
  localparam logic [STATUS_W-1:0] ST_LEFT_FORWARD   = 8'b0000_1000;
  localparam logic [STATUS_W-1:0] ST_LEFT_BACKWARD  = 8'b0000_0100;
  localparam logic [STATUS_W-1:0] ST_RIGHT_FORWARD  = 8'b0000_0010;
  localparam logic [STATUS_W-1:0] ST_RIGHT_BACKWARD = 8'b0000_0001;

  // classification outcomes
  localparam logic [STATUS_W-1:0] ST_LEFT_STEP  = ST_RAISED_LEFT | ST_LEFT_FORWARD |
                                                  ST_LOWERED_RIGHT | ST_RIGHT_BACKWARD;
  localparam logic [STATUS_W-1:0] ST_RIGHT_STEP = ST_LOWERED_LEFT | ST_LEFT_BACKWARD |
                                                  ST_RAISED_RIGHT | ST_RIGHT_FORWARD;
  localparam logic [STATUS_W-1:0] ST_LEFT_SLIDE = ST_LOWERED_LEFT | ST_LEFT_FORWARD |
                                                  ST_LOWERED_RIGHT | ST_RIGHT_BACKWARD;
  localparam logic [STATUS_W-1:0] ST_RIGHT_SLIDE = ST_LOWERED_LEFT | ST_LEFT_BACKWARD |
                                                   ST_LOWERED_RIGHT | ST_RIGHT_FORWARD;
  localparam logic [STATUS_W-1:0] ST_SQUAT      = ST_LOWERED_LEFT | ST_LOWERED_RIGHT;
  localparam logic [STATUS_W-1:0] ST_NONE       = '0;

  // tracker state seen by the classifier
  typedef struct packed {
    logic [MARGIN_W-1:0]     margin;
    logic signed [SUM_W-1:0] sum_hl;
    logic signed [SUM_W-1:0] sum_hr;
    logic signed [AXIS_W-1:0] hl_y;
    logic signed [AXIS_W-1:0] hr_y;
    logic signed [AXIS_W-1:0] ll_y;
    logic signed [AXIS_W-1:0] lr_y;
    logic signed [AXIS_W-1:0] ll_z;
    logic signed [AXIS_W-1:0] lr_z;
  } gpc_state_t;

endpackage

>>> sv/gpc_if.sv
// ----------------------------------------------------------------------------
// gpc_if: valid/ready channels of the gait phase classifier
// Sensor reading channel and leg-status result channel.
// ----------------------------------------------------------------------------
interface gpc_sensor_if;
  logic                                valid;
  logic                                ready;
  logic [gpc_pkg::POS_W-1:0]           position;
  logic signed [gpc_pkg::AXIS_W-1:0]   acc_x;
  logic signed [gpc_pkg::AXIS_W-1:0]   acc_y;
  logic signed [gpc_pkg::AXIS_W-1:0]   acc_z;

  modport source (output valid, position, acc_x, acc_y, acc_z, input ready);
  modport sink   (input valid, position, acc_x, acc_y, acc_z, output ready);
endinterface

interface gpc_result_if;
  logic                              valid;
  logic                              ready;
  logic [gpc_pkg::STATUS_W-1:0]      leg_status;
  logic                              calibrated;

  modport source (output valid, leg_status, calibrated, input ready);
  modport sink   (input valid, leg_status, calibrated, output ready);
endinterface

>>> sv/imu_gait_phase_classifier_top.sv
// ----------------------------------------------------------------------------
// imu_gait_phase_classifier_top: four-sensor gait phase classifier
// Takes one leg accelerometer reading per item and gives one leg-status
// result per frame end (low-right reading).
// ----------------------------------------------------------------------------
// The block accepts one reading per clock cycle. A reading updates the axis
// latches and calibration state at the edge that accepts it; a frame-end
// reading sets a pending flag, and the classifier works from the updated
// state into the result register once that register is free; result valid
// rises with that write. The first CAL_FRAMES frames give results with
// leg_status 0 and calibrated 0. Input ready drops only while a frame result
// is pending and the result register is still held by the sink; with the sink
// always ready, throughput is one reading per cycle.
module imu_gait_phase_classifier_top (
  input  logic          clk,
  input  logic          rst,
  gpc_sensor_if.sink    sensor,
  gpc_result_if.source  result
);
  import gpc_pkg::*;

  logic                accept;
  logic                calibrating;
  logic [CNT_W-1:0]    frame_count;
  gpc_state_t          state;
  logic [STATUS_W-1:0] status;
  logic                pend;
  logic                pend_cal;
  logic                out_valid;
  logic                out_free;
  logic [STATUS_W-1:0] leg_status;
  logic                calibrated;

  assign out_free     = !out_valid || result.ready;
  assign sensor.ready = !pend || out_free;
  assign accept       = sensor.valid && sensor.ready;

  gpc_track u_track (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .position    (sensor.position),
    .acc_x       (sensor.acc_x),
    .acc_y       (sensor.acc_y),
    .acc_z       (sensor.acc_z),
    .calibrating (calibrating),
    .frame_count (frame_count),
    .state       (state)
  );

  gpc_classify u_classify (
    .state  (state),
    .status (status)
  );

  // pending frame end and result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= pend;
      end
      if (accept) begin
        pend <= (sensor.position == POS_LOW_RIGHT);
      end else if (out_free) begin
        pend <= 1'b0;
      end
    end
  end

  // pending payload and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_cal <= !calibrating;
    end
    if (out_free && pend) begin
      leg_status <= pend_cal ? status : ST_NONE;
      calibrated <= pend_cal;
    end
  end

  assign result.valid      = out_valid;
  assign result.leg_status = leg_status;
  assign result.calibrated = calibrated;

`ifndef ASSERT_OFF
  // calibration frame results carry no status
  a_cal_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !calibrated) |-> (leg_status == ST_NONE))
    else $error("calibration result with nonzero status");

  // status is one of the six classification outcomes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (leg_status == ST_LEFT_STEP || leg_status == ST_RIGHT_STEP ||
                   leg_status == ST_LEFT_SLIDE || leg_status == ST_RIGHT_SLIDE ||
                   leg_status == ST_SQUAT || leg_status == ST_NONE))
    else $error("unknown leg status code");

  // frame counter saturates at the calibration length
  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    frame_count <= CNT_W'(CAL_FRAMES))
    else $error("frame count beyond calibration length");

  // a pending frame end is never overwritten while the result is stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (pend && out_valid && !result.ready) |=> pend)
    else $error("pending frame result lost");
`endif
endmodule

>>> sv/gpc_track.sv
// ----------------------------------------------------------------------------
// gpc_track: per-item state update
// Latches the newest axes per position, and during calibration raises the
// noise margin, accumulates the high vertical sums and counts frames.
// ----------------------------------------------------------------------------
module gpc_track (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic [gpc_pkg::POS_W-1:0]          position,
  input  logic signed [gpc_pkg::AXIS_W-1:0]  acc_x,
  input  logic signed [gpc_pkg::AXIS_W-1:0]  acc_y,
  input  logic signed [gpc_pkg::AXIS_W-1:0]  acc_z,
  output logic                               calibrating,
  output logic [gpc_pkg::CNT_W-1:0]          frame_count,
  output gpc_pkg::gpc_state_t                state
);
  import gpc_pkg::*;

  logic [MARGIN_W-1:0]      margin;
  logic [MARGIN_W-1:0]      margin_next;
  logic signed [SUM_W-1:0]  sum_hl;
  logic signed [SUM_W-1:0]  sum_hr;
  logic signed [AXIS_W-1:0] hl_y, hr_y, ll_y, lr_y, ll_z, lr_z;
  logic signed [AXIS_W-1:0] max_xy;
  logic signed [AXIS_W-1:0] max_xyz;
  logic signed [SUM_W-1:0]  y_ext;

  assign calibrating = (frame_count < CNT_W'(CAL_FRAMES));
  assign y_ext       = SUM_W'(acc_y);

  // largest of the three axes; margin only rises
  always_comb begin
    max_xy      = (acc_x > acc_y) ? acc_x : acc_y;
    max_xyz     = (max_xy > acc_z) ? max_xy : acc_z;
    margin_next = margin;
    if (max_xyz > $signed({1'b0, margin})) begin
      margin_next = max_xyz[MARGIN_W-1:0];
    end
  end

  // control and calibration state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      margin      <= '0;
      sum_hl      <= '0;
      sum_hr      <= '0;
    end else if (accept && calibrating) begin
      margin <= margin_next;
      if (position == POS_HIGH_LEFT) begin
        sum_hl <= sum_hl + y_ext;
      end
      if (position == POS_HIGH_RIGHT) begin
        sum_hr <= sum_hr + y_ext;
      end
      if (position == POS_LOW_RIGHT) begin
        frame_count <= frame_count + 1'b1;
      end
    end
  end

  // axis latches, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      unique case (position)
        POS_HIGH_LEFT:  hl_y <= acc_y;
        POS_HIGH_RIGHT: hr_y <= acc_y;
        POS_LOW_LEFT: begin
          ll_y <= acc_y;
          ll_z <= acc_z;
        end
        POS_LOW_RIGHT: begin
          lr_y <= acc_y;
          lr_z <= acc_z;
        end
        default: ;
      endcase
    end
  end

  assign state = '{margin: margin, sum_hl: sum_hl, sum_hr: sum_hr,
                   hl_y: hl_y, hr_y: hr_y, ll_y: ll_y, lr_y: lr_y,
                   ll_z: ll_z, lr_z: lr_z};
endmodule

>>> sv/gpc_classify.sv
// ----------------------------------------------------------------------------
// gpc_classify: frame classification
// Five prioritized margin comparisons on the latched vertical and forward
// axes; the squat test compares against the calibration averages exactly.
// ----------------------------------------------------------------------------
module gpc_classify (
  input  gpc_pkg::gpc_state_t             state,
  output logic [gpc_pkg::STATUS_W-1:0]    status
);
  import gpc_pkg::*;

  localparam int CMP_W = AXIS_W + 1;
  localparam logic signed [PROD_W-1:0] CalN = PROD_W'(CAL_FRAMES);

  logic signed [CMP_W-1:0]  m;
  logic signed [CMP_W-1:0]  hl, hr, ll, lr, llz, lrz;
  logic signed [CMP_W-1:0]  hl_m, hr_m, ll_m, lr_m, llz_m, lrz_m;
  logic signed [PROD_W-1:0] hl_scaled, hr_scaled;
  logic signed [PROD_W-1:0] sum_hl, sum_hr;

  // axis plus margin, one bit of headroom
  always_comb begin
    m     = $signed({2'b00, state.margin});
    hl    = CMP_W'(state.hl_y);
    hr    = CMP_W'(state.hr_y);
    ll    = CMP_W'(state.ll_y);
    lr    = CMP_W'(state.lr_y);
    llz   = CMP_W'(state.ll_z);
    lrz   = CMP_W'(state.lr_z);
    hl_m  = hl + m;
    hr_m  = hr + m;
    ll_m  = ll + m;
    lr_m  = lr + m;
    llz_m = llz + m;
    lrz_m = lrz + m;
    // x < sum/N - m  <=>  N*(x+m) < sum
    hl_scaled = PROD_W'(hl_m) * CalN;
    hr_scaled = PROD_W'(hr_m) * CalN;
    sum_hl    = PROD_W'(state.sum_hl);
    sum_hr    = PROD_W'(state.sum_hr);
  end

  // first match wins
  always_comb begin
    priority if (hl > hr_m && ll > lr_m) begin
      status = ST_LEFT_STEP;
    end else if (hr > hl_m && lr > ll_m) begin
      status = ST_RIGHT_STEP;
    end else if (hl < hr_m && llz > lrz_m) begin
      status = ST_LEFT_SLIDE;
    end else if (hr < hl_m && lrz > llz_m) begin
      status = ST_RIGHT_SLIDE;
    end else if (hr_scaled < sum_hr && hl_scaled < sum_hl) begin
      status = ST_SQUAT;
    end else begin
      status = ST_NONE;
    end
  end
endmodule

>>> tb/sv/tb_imu_gait_phase_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_gait_phase_classifier_top: self-checking bench for the gait classifier
// Runs the calibration frames, a short directed pass through each leg-status
// outcome and its boundaries, then random frames under source idling and
// sink stalls. Every frame-end result is checked against an in-bench model.
// ----------------------------------------------------------------------------
module tb_imu_gait_phase_classifier_top;
  import gpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 16;
  localparam int CAL_SPAN       = 3000;
  localparam int FULL_SPAN      = 32768;

  typedef struct packed {
    logic [STATUS_W-1:0] leg_status;
    logic                calibrated;
  } gait_result_t;

  logic clk;
  logic rst;

  gpc_sensor_if sensor_ch ();
  gpc_result_if result_ch ();

  imu_gait_phase_classifier_top u_top (
    .clk    (clk),
    .rst    (rst),
    .sensor (sensor_ch.sink),
    .result (result_ch.source)
  );

  // model state of the classifier
  logic [CNT_W-1:0]         cal_frames_seen;
  logic [MARGIN_W-1:0]      noise_margin;
  logic signed [SUM_W-1:0]  sum_high_left;
  logic signed [SUM_W-1:0]  sum_high_right;
  logic signed [AXIS_W-1:0] hl_y, hr_y, ll_y, lr_y, ll_z, lr_z;

  gait_result_t expected_status_q[$];

  int src_idle_pct;
  int snk_stall_pct;
  int readings_sent;
  int err_cnt;
  int results_checked;
  int results_cal;
  int hits_step, hits_slide, hits_squat, hits_none;
  int idle_cycles;

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // model
  // ---------------------------------------------------------------------------
  function automatic void bump_margin(input int v);
    if (v > int'(noise_margin)) noise_margin = v[MARGIN_W-1:0];
  endfunction

  // prioritized leg-status decision over the latched axes
  function automatic logic [STATUS_W-1:0] classify_frame();
    int m, hl, hr, ll, lr, llz, lrz;
    longint n;
    m   = int'(noise_margin);
    hl  = hl_y;
    hr  = hr_y;
    ll  = ll_y;
    lr  = lr_y;
    llz = ll_z;
    lrz = lr_z;
    n   = CAL_FRAMES;
    if (hl > hr + m && ll > lr + m) return ST_LEFT_STEP;
    if (hr > hl + m && lr > ll + m) return ST_RIGHT_STEP;
    if (hl < hr + m && llz > lrz + m) return ST_LEFT_SLIDE;
    if (hr < hl + m && lrz > llz + m) return ST_RIGHT_SLIDE;
    // below average minus margin, kept exact: n*(x+m) < sum
    if (n * (longint'(hr) + m) < longint'(sum_high_right) &&
        n * (longint'(hl) + m) < longint'(sum_high_left))
      return ST_SQUAT;
    return ST_NONE;
  endfunction

  // update the model with one accepted reading, queue the frame result
  task automatic track_reading(input pos_t p, input logic signed [AXIS_W-1:0] ax, ay, az);
    gait_result_t r;
    logic         calibrating;
    calibrating = (cal_frames_seen < CAL_FRAMES);
    case (p)
      POS_HIGH_LEFT:  hl_y = ay;
      POS_HIGH_RIGHT: hr_y = ay;
      POS_LOW_LEFT: begin
        ll_y = ay;
        ll_z = az;
      end
      default: begin
        lr_y = ay;
        lr_z = az;
      end
    endcase
    if (calibrating) begin
      bump_margin(ax);
      bump_margin(ay);
      bump_margin(az);
      if (p == POS_HIGH_LEFT) sum_high_left = sum_high_left + ay;
      else if (p == POS_HIGH_RIGHT) sum_high_right = sum_high_right + ay;
    end
    if (p == POS_LOW_RIGHT) begin
      if (calibrating) begin
        cal_frames_seen = cal_frames_seen + 1'b1;
        r.leg_status = ST_NONE;
        r.calibrated = 1'b0;
      end else begin
        r.leg_status = classify_frame();
        r.calibrated = 1'b1;
      end
      expected_status_q.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // value helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [AXIS_W-1:0] clip16(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[AXIS_W-1:0];
  endfunction

  function automatic logic signed [AXIS_W-1:0] rand_near(input int center, input int span);
    int r;
    r = center - span + int'($urandom_range(2 * span));
    return clip16(r);
  endfunction

  function automatic logic signed [AXIS_W-1:0] rand_axis(input int span);
    logic signed [AXIS_W-1:0] r;
    r = AXIS_W'($urandom);
    if (span >= FULL_SPAN) return r;
    return rand_near(0, span);
  endfunction

  // ---------------------------------------------------------------------------
  // sensor driver
  // ---------------------------------------------------------------------------
  task automatic send_reading(input pos_t p, input logic signed [AXIS_W-1:0] ax, ay, az);
    while ($urandom_range(99) < src_idle_pct) begin
      sensor_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sensor_ch.valid    <= 1'b1;
    sensor_ch.position <= p;
    sensor_ch.acc_x    <= ax;
    sensor_ch.acc_y    <= ay;
    sensor_ch.acc_z    <= az;
    do @(posedge clk); while (!sensor_ch.ready);
    readings_sent++;
    track_reading(p, ax, ay, az);
  endtask

  // one frame: the three non-final positions in random order, then low right;
  // shaped frames sometimes drop a position or repeat one
  task automatic send_frame(input logic signed [AXIS_W-1:0] hly, hry, lly, lry, llz, lrz,
                            input int span, input bit shaped);
    logic signed [AXIS_W-1:0] ys[4];
    logic signed [AXIS_W-1:0] zs[4];
    pos_t ord[3];
    pos_t t;
    int   j;
    int   skip;
    ys[0] = hly;  ys[1] = hry;  ys[2] = lly;  ys[3] = lry;
    zs[0] = rand_axis(span);  zs[1] = rand_axis(span);  zs[2] = llz;  zs[3] = lrz;
    ord[0] = POS_HIGH_LEFT;
    ord[1] = POS_HIGH_RIGHT;
    ord[2] = POS_LOW_LEFT;
    for (int i = 2; i > 0; i--) begin
      j = $urandom_range(i);
      t = ord[i];
      ord[i] = ord[j];
      ord[j] = t;
    end
    skip = -1;
    if (shaped && $urandom_range(99) < 8) skip = $urandom_range(2);
    for (int i = 0; i < 3; i++) begin
      if (i != skip)
        send_reading(ord[i], rand_axis(span), ys[int'(ord[i])], zs[int'(ord[i])]);
    end
    // repeated position: the latch keeps the later reading
    if (shaped && $urandom_range(99) < 10) begin
      j = $urandom_range(2);
      send_reading(pos_t'(j), rand_axis(span), rand_axis(span), rand_axis(span));
    end
    send_reading(POS_LOW_RIGHT, rand_axis(span), lry, lrz);
  endtask

  // source holds off until every queued result has come back
  task automatic wait_results_drained();
    sensor_ch.valid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_calibration();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    // first frame: negative extremes never raise the margin, high left repeated
    send_reading(POS_HIGH_LEFT, -32768, -32768, -32768);
    send_reading(POS_HIGH_RIGHT, 0, -32768, 0);
    send_reading(POS_HIGH_LEFT, 100, 2000, 50);
    send_reading(POS_LOW_LEFT, -5, 10, 20);
    send_reading(POS_LOW_RIGHT, CAL_SPAN, -CAL_SPAN, 1);
    // frame with the high positions missing
    send_reading(POS_LOW_LEFT, 7, 300, -300);
    send_reading(POS_LOW_RIGHT, -7, -300, 300);
    for (int f = 2; f < CAL_FRAMES; f++) begin
      if ($urandom_range(99) < 8)
        send_reading(POS_LOW_RIGHT, rand_axis(CAL_SPAN), rand_axis(CAL_SPAN),
                     rand_axis(CAL_SPAN));
      else
        send_frame(rand_near(1750, 1250), rand_near(1750, 1250), rand_axis(CAL_SPAN),
                   rand_axis(CAL_SPAN), rand_axis(CAL_SPAN), rand_axis(CAL_SPAN),
                   CAL_SPAN, 1'b1);
    end
    wait_results_drained();
  endtask

  // each outcome once, exact margin boundaries and field extremes
  task automatic test_directed_outcomes();
    int m;
    m = int'(noise_margin);
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    send_frame(m + 1, 0, m + 1, 0, 0, 0, 0, 1'b0);                    // left step
    send_frame(0, m + 1, 0, m + 1, 0, 0, 0, 1'b0);                    // right step
    send_reading(POS_LOW_LEFT, 0, 0, m + 1);                          // left slide
    send_reading(POS_LOW_RIGHT, 0, 0, 0);
    send_reading(POS_HIGH_RIGHT, 0, 0, 0);                            // right slide
    send_reading(POS_LOW_LEFT, 0, 0, 0);
    send_reading(POS_LOW_RIGHT, 0, 0, m + 1);
    send_reading(POS_HIGH_LEFT, -32768, -32768, -32768);              // squat
    send_reading(POS_HIGH_RIGHT, -32768, -32768, -32768);
    send_reading(POS_LOW_RIGHT, 0, 0, 0);
    send_reading(POS_HIGH_LEFT, 32767, 32767, 32767);                 // extremes
    send_reading(POS_HIGH_RIGHT, 32767, 32767, 32767);
    send_reading(POS_LOW_LEFT, -32768, -32768, -32768);
    send_reading(POS_LOW_RIGHT, 32767, -32768, 32767);
    send_reading(POS_LOW_RIGHT, -32768, 32767, -32768);               // lone frame end
    send_frame(m, 0, m, 0, m, 0, 0, 1'b0);                            // equal to margin
    wait_results_drained();
  endtask

  task automatic test_random_frames(input int src_pct, input int snk_pct, input int n_items);
    int stop;
    int m;
    int mode;
    logic signed [AXIS_W-1:0] v[6];
    logic signed [AXIS_W-1:0] t;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    stop = readings_sent + n_items;
    m = int'(noise_margin);
    while (readings_sent < stop) begin
      // stray reading outside a full frame
      if ($urandom_range(99) < 5)
        send_reading(pos_t'($urandom_range(2)), rand_axis(FULL_SPAN), rand_axis(FULL_SPAN),
                     rand_axis(FULL_SPAN));
      mode = $urandom_range(99);
      if (mode < 25) begin
        for (int i = 0; i < 6; i++) v[i] = rand_axis(FULL_SPAN);
      end else if (mode < 65) begin
        for (int i = 0; i < 6; i++) v[i] = rand_near(0, 2 * m + 64);
      end else begin
        // pairs placed around the margin boundary
        for (int i = 0; i < 6; i++) v[i] = rand_near(0, 12000);
        v[0] = clip16(int'(v[1]) + m + int'($urandom_range(2)) - 1);
        v[2] = clip16(int'(v[3]) + m + int'($urandom_range(2)) - 1);
        v[4] = clip16(int'(v[5]) + m + int'($urandom_range(2)) - 1);
        if ($urandom_range(1)) begin
          t = v[0]; v[0] = v[1]; v[1] = t;
          t = v[2]; v[2] = v[3]; v[3] = t;
          t = v[4]; v[4] = v[5]; v[5] = t;
        end
        // both high sensors well below their averages
        if ($urandom_range(3) == 0) begin
          v[0] = rand_near(-20000, 10000);
          v[1] = rand_near(-20000, 10000);
        end
      end
      send_frame(v[0], v[1], v[2], v[3], v[4], v[5],
                 (mode < 25) ? FULL_SPAN : 2 * m + 64, 1'b1);
    end
    wait_results_drained();
  endtask

  // ---------------------------------------------------------------------------
  // result sink: random stalls, check each result in order
  // ---------------------------------------------------------------------------
  initial result_ch.ready = 1'b0;

  always @(posedge clk) begin : result_check
    gait_result_t want;
    result_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_status_q.size() == 0) begin
        $error("unexpected result: leg_status %02h calibrated %0b",
               result_ch.leg_status, result_ch.calibrated);
        err_cnt++;
      end else begin
        want = expected_status_q.pop_front();
        results_checked++;
        if (result_ch.leg_status !== want.leg_status) begin
          $error("leg_status mismatch: expected %02h, actual %02h",
                 want.leg_status, result_ch.leg_status);
          err_cnt++;
        end
        if (result_ch.calibrated !== want.calibrated) begin
          $error("calibrated mismatch: expected %0b, actual %0b",
                 want.calibrated, result_ch.calibrated);
          err_cnt++;
        end
        if (!want.calibrated) results_cal++;
        else if (want.leg_status == ST_LEFT_STEP || want.leg_status == ST_RIGHT_STEP)
          hits_step++;
        else if (want.leg_status == ST_LEFT_SLIDE || want.leg_status == ST_RIGHT_SLIDE)
          hits_slide++;
        else if (want.leg_status == ST_SQUAT) hits_squat++;
        else hits_none++;
      end
    end
  end

  // watchdog: cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (sensor_ch.valid && sensor_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                = 1'b1;
    sensor_ch.valid    = 1'b0;
    sensor_ch.position = POS_HIGH_LEFT;
    sensor_ch.acc_x    = '0;
    sensor_ch.acc_y    = '0;
    sensor_ch.acc_z    = '0;
    cal_frames_seen    = '0;
    noise_margin       = '0;
    sum_high_left      = '0;
    sum_high_right     = '0;
    hl_y = '0;  hr_y = '0;  ll_y = '0;  lr_y = '0;  ll_z = '0;  lr_z = '0;
    src_idle_pct    = 0;
    snk_stall_pct   = 0;
    readings_sent   = 0;
    err_cnt         = 0;
    results_checked = 0;
    results_cal     = 0;
    hits_step       = 0;
    hits_slide      = 0;
    hits_squat      = 0;
    hits_none       = 0;
    idle_cycles     = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_calibration();
    test_directed_outcomes();
    test_random_frames(0, 0, 265);
    test_random_frames(55, 0, 265);
    test_random_frames(0, 55, 265);
    test_random_frames(30, 30, 265);

    src_idle_pct  = 0;
    snk_stall_pct = 0;
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d readings, %0d frame results (%0d during calibration).",
             readings_sent, results_checked, results_cal);
    $display("Outcomes after calibration: %0d steps, %0d slides, %0d squats, %0d neutral.",
             hits_step, hits_slide, hits_squat, hits_none);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/gpc_pkg.sv
sv/gpc_if.sv
sv/gpc_track.sv
sv/gpc_classify.sv
sv/imu_gait_phase_classifier_top.sv
tb/sv/tb_imu_gait_phase_classifier_top.sv
